>>> hdl/i2cbm_pkg.sv
package i2cbm_pkg;

   localparam int TickCountWidthDefault = 16;
   localparam int HalfPeriodWidth = 16;
   localparam logic [HalfPeriodWidth-1:0] HalfPeriodReset = 16'd50;

   localparam logic [4:0] WritePhases = 5'd28;
   localparam logic [4:0] ReadPhases = 5'd20;
   localparam logic [4:0] ShortPhases = 5'd2;
   localparam logic [4:0] ReadSamplePhases = 5'd16;

   typedef enum logic [2:0] {
      CMD_IDLE  = 3'd0,
      CMD_START = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_READ  = 3'd3,
      CMD_STOP  = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] data_byte;
      logic       ack_release;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic scl;
      logic sda;
   } pins_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
   } result_type;

   function automatic logic [4:0] phase_total(cmd_type cmd);
      logic [4:0] total;
      case (cmd)
         CMD_WRITE: total = WritePhases;
         CMD_READ:  total = ReadPhases;
         default:   total = ShortPhases;
      endcase
      return total;
   endfunction

   // Pin levels at the start of phase p of a command. Write phases 1 to 24
   // come in groups of three per bit: set data, raise SCL, lower SCL.
   function automatic pins_type begin_phase(cmd_type cmd, logic [4:0] p,
                                            logic [7:0] shift, logic ack,
                                            pins_type cur);
      pins_type   r;
      logic [4:0] q;
      logic [8:0] prod;
      logic [2:0] b;
      logic [1:0] rem;
      r = cur;
      q = p - 5'd1;
      prod = 9'(q) * 9'd11;
      b = prod[7:5];
      rem = 2'(q - 5'({b, 1'b0}) - 5'(b));
      case (cmd)
         CMD_START: begin
            if (p == 5'd0) begin
               r.sda = 1'b1;
               r.scl = 1'b1;
            end else begin
               r.sda = 1'b0;
            end
         end
         CMD_STOP: begin
            if (p == 5'd0) begin
               r.scl = 1'b1;
            end else begin
               r.sda = 1'b1;
            end
         end
         CMD_WRITE: begin
            if (p == 5'd0) begin
               r.scl = 1'b0;
            end else if (p <= 5'd24) begin
               case (rem)
                  2'd0:    r.sda = shift[3'd7 - b];
                  2'd1:    r.scl = 1'b1;
                  default: r.scl = 1'b0;
               endcase
            end else if (p == 5'd25) begin
               r.sda = 1'b0;
            end else if (p == 5'd26) begin
               r.scl = 1'b1;
            end else begin
               r.scl = 1'b0;
            end
         end
         CMD_READ: begin
            if (p < ReadSamplePhases) begin
               if (p == 5'd0) begin
                  r.sda = 1'b1;
               end
               r.scl = ~p[0];
            end else if (p == 5'd16) begin
               r.sda = ack;
            end else if (p == 5'd17) begin
               r.scl = 1'b1;
            end else if (p == 5'd18) begin
               r.scl = 1'b0;
            end else begin
               r.sda = 1'b0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/i2cbm_in_reg.sv
module i2cbm_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cbm_pkg::item_type req_item,
   input  logic                take,
   output logic                item_valid,
   output i2cbm_pkg::item_type item
);

   logic                valid_ff;
   logic                valid_in;
   i2cbm_pkg::item_type item_ff;

   assign req_ready = ~valid_ff | take;
   assign valid_in = (req_valid & req_ready) | (valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

>>> hdl/i2cbm_core.sv
module i2cbm_core #(
   parameter int TICK_COUNT_WIDTH = i2cbm_pkg::TickCountWidthDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [i2cbm_pkg::HalfPeriodWidth-1:0]  csr_wr_data,
   input  logic                                   step,
   input  i2cbm_pkg::item_type                    item,
   output i2cbm_pkg::result_type                  result
);

   localparam int CmpWidth = (TICK_COUNT_WIDTH > i2cbm_pkg::HalfPeriodWidth) ?
                             TICK_COUNT_WIDTH : i2cbm_pkg::HalfPeriodWidth;

   i2cbm_pkg::cmd_type                    cmd_ff, cmd_in;
   logic [4:0]                            phase_ff, phase_in;
   logic [TICK_COUNT_WIDTH-1:0]           tick_ff, tick_in;
   logic [7:0]                            shift_ff, shift_in;
   logic                                  ack_ff, ack_in;
   i2cbm_pkg::pins_type                   pins_ff, pins_in;
   logic [7:0]                            read_ff, read_in;
   logic [i2cbm_pkg::HalfPeriodWidth-1:0] half_ff;
   logic [TICK_COUNT_WIDTH-1:0]           tick_next;
   logic [4:0]                            phase_next;
   logic                                  phase_end;
   logic                                  done;

   assign tick_next = tick_ff + TICK_COUNT_WIDTH'(1);
   assign phase_next = phase_ff + 5'd1;
   assign phase_end = (CmpWidth'(tick_next) >= CmpWidth'(half_ff)) ||
                      (tick_next == {TICK_COUNT_WIDTH{1'b1}});

   always_comb begin
      cmd_in = cmd_ff;
      phase_in = phase_ff;
      tick_in = tick_ff;
      shift_in = shift_ff;
      ack_in = ack_ff;
      pins_in = pins_ff;
      read_in = read_ff;
      done = 1'b0;
      if (step) begin
         if (cmd_ff == i2cbm_pkg::CMD_IDLE) begin
            case (item.func) inside
               i2cbm_pkg::CMD_START, i2cbm_pkg::CMD_WRITE,
               i2cbm_pkg::CMD_READ, i2cbm_pkg::CMD_STOP: begin
                  cmd_in = i2cbm_pkg::cmd_type'(item.func);
                  phase_in = 5'd0;
                  tick_in = '0;
                  if (item.func == i2cbm_pkg::CMD_WRITE) begin
                     shift_in = item.data_byte;
                  end
                  if (item.func == i2cbm_pkg::CMD_READ) begin
                     shift_in = 8'd0;
                     ack_in = item.ack_release;
                  end
                  pins_in = i2cbm_pkg::begin_phase(cmd_in, 5'd0, shift_in, ack_in,
                                                   pins_ff);
               end
               default: ;
            endcase
         end else if (item.func == i2cbm_pkg::CMD_IDLE) begin
            if (phase_end) begin
               tick_in = '0;
               if (cmd_ff == i2cbm_pkg::CMD_READ && phase_ff < i2cbm_pkg::ReadSamplePhases
                   && !phase_ff[0] && item.sda_in) begin
                  shift_in[3'd7 - phase_ff[3:1]] = 1'b1;
               end
               if (phase_next >= i2cbm_pkg::phase_total(cmd_ff)) begin
                  if (cmd_ff == i2cbm_pkg::CMD_READ) begin
                     read_in = shift_in;
                  end
                  cmd_in = i2cbm_pkg::CMD_IDLE;
                  phase_in = 5'd0;
                  done = 1'b1;
               end else begin
                  phase_in = phase_next;
                  pins_in = i2cbm_pkg::begin_phase(cmd_ff, phase_next, shift_in,
                                                   ack_ff, pins_ff);
               end
            end else begin
               tick_in = tick_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= i2cbm_pkg::CMD_IDLE;
         phase_ff <= 5'd0;
         tick_ff <= '0;
         shift_ff <= 8'd0;
         ack_ff <= 1'b0;
         pins_ff <= '{scl: 1'b1, sda: 1'b1};
         read_ff <= 8'd0;
         half_ff <= i2cbm_pkg::HalfPeriodReset;
      end else begin
         cmd_ff <= cmd_in;
         phase_ff <= phase_in;
         tick_ff <= tick_in;
         shift_ff <= shift_in;
         ack_ff <= ack_in;
         pins_ff <= pins_in;
         read_ff <= read_in;
         if (csr_wr_en) begin
            half_ff <= csr_wr_data;
         end
      end
   end

   assign result.scl_release = pins_in.scl;
   assign result.sda_release = pins_in.sda;
   assign result.busy_res = (cmd_in != i2cbm_pkg::CMD_IDLE);
   assign result.done_res = done;
   assign result.read_byte = read_in;

endmodule

>>> hdl/i2c_bit_level_master.sv
// Each transaction is registered at the input and again at the result.
// Throughput: one transaction per cycle while the result side keeps taking them.
// Each tick or command is one update of the sequencer state between the input
// register and the result register.
// Reset is synchronous: the bus lines are released, the block goes idle and
// the half period returns to 50 ticks.
module i2c_bit_level_master #(
   parameter int TICK_COUNT_WIDTH = i2cbm_pkg::TickCountWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        req_ack_release,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_release,
   output logic        rsp_sda_release,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_byte,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   i2cbm_pkg::item_type   req_item;
   i2cbm_pkg::item_type   item;
   i2cbm_pkg::result_type result;
   i2cbm_pkg::result_type rsp_ff;
   logic                  item_valid;
   logic                  out_load;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   assign req_item = '{func: req_func, data_byte: req_data_byte,
                       ack_release: req_ack_release, sda_in: req_sda_in};
   assign out_load = item_valid & (~rsp_valid_ff | rsp_ready);

   i2cbm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (out_load),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cbm_core #(
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (out_load),
      .item        (item),
      .result      (result)
   );

   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_scl_release = rsp_ff.scl_release;
   assign rsp_sda_release = rsp_ff.sda_release;
   assign rsp_busy_res = rsp_ff.busy_res;
   assign rsp_done_res = rsp_ff.done_res;
   assign rsp_read_byte = rsp_ff.read_byte;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("Completed command still reports busy.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("Input stalled while the result side is ready.");

   assert property (@(posedge clock) disable iff (reset)
      item_valid && !out_load |=> item_valid)
      else $error("Buffered transaction dropped before processing.");
`endif

endmodule
